// ===== rtl/uirx_pkg.sv =====
// Shared types and constants for the infrared UART byte receiver.
package uirx_pkg;

	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 16;
	localparam int BITCNT_W = 4;
	localparam int LAST_BIT = 7;

	localparam logic [CNT_W-1:0] START_DELAY_RST = 16'd2083;
	localparam logic [CNT_W-1:0] BIT_PERIOD_RST  = 16'd2083;

	// Item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// Register indexes
	localparam logic CFG_START_DELAY = 1'b0;
	localparam logic CFG_BIT_PERIOD  = 1'b1;

	typedef struct packed {
		logic             we;
		logic             index;
		logic [CNT_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} push_t;

	typedef struct packed {
		logic empty;
		logic was_full;
	} pop_stat_t;

endpackage

// ===== rtl/uirx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module uirx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/uirx_rx.sv =====
// Line sampler: start edge detect, bit countdown and byte assembly.
module uirx_rx (
	input  logic                clk,
	input  logic                arst_n,
	input  uirx_pkg::cfg_wr_t   cfg,
	input  logic                tick,
	input  logic                level,
	output uirx_pkg::push_t     push
);

	logic [uirx_pkg::CNT_W-1:0]    start_delay_q;
	logic [uirx_pkg::CNT_W-1:0]    bit_period_q;
	logic                          reading_q;
	logic                          prev_level_q;
	logic [uirx_pkg::BITCNT_W-1:0] bit_cnt_q;
	logic [uirx_pkg::BYTE_W-1:0]   shift_q;
	logic [uirx_pkg::CNT_W-1:0]    countdown_q;

	logic                          start_edge;
	logic                          sample;
	logic [uirx_pkg::BITCNT_W-1:0] bit_cnt_nxt;
	logic [uirx_pkg::BYTE_W-1:0]   shift_nxt;
	logic                          done;

	assign start_edge  = !reading_q && prev_level_q && !level;
	assign sample      = reading_q && (countdown_q <= uirx_pkg::CNT_W'(1));
	assign bit_cnt_nxt = bit_cnt_q + uirx_pkg::BITCNT_W'(1);
	assign shift_nxt   = shift_q | (uirx_pkg::BYTE_W'(level) << bit_cnt_q[2:0]);
	assign done        = bit_cnt_nxt > uirx_pkg::BITCNT_W'(uirx_pkg::LAST_BIT);

	assign push.valid = tick && sample && done;
	assign push.data  = shift_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q <= uirx_pkg::START_DELAY_RST;
			bit_period_q  <= uirx_pkg::BIT_PERIOD_RST;
		end else if (cfg.we) begin
			unique case (cfg.index)
				uirx_pkg::CFG_START_DELAY: start_delay_q <= cfg.data;
				uirx_pkg::CFG_BIT_PERIOD:  bit_period_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_q    <= 1'b0;
			prev_level_q <= 1'b1;
			bit_cnt_q    <= '0;
			shift_q      <= '0;
			countdown_q  <= '0;
		end else if (tick) begin
			prev_level_q <= level;
			if (start_edge) begin
				reading_q   <= 1'b1;
				bit_cnt_q   <= '0;
				shift_q     <= '0;
				countdown_q <= start_delay_q;
			end else if (sample) begin
				shift_q     <= shift_nxt;
				bit_cnt_q   <= bit_cnt_nxt;
				countdown_q <= bit_period_q;
				if (done) begin
					reading_q <= 1'b0;
				end
			end else if (reading_q) begin
				countdown_q <= countdown_q - uirx_pkg::CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/uirx_fifo.sv =====
// Receive FIFO: ring pointers, full flag and the byte store RAM.
module uirx_fifo #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uirx_pkg::push_t               push,
	input  logic                          pop,
	output uirx_pkg::pop_stat_t           stat,
	output logic [uirx_pkg::BYTE_W-1:0]   rdata
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic             full_q;

	logic [PTR_W-1:0] wr_ptr_nxt;
	logic [PTR_W-1:0] rd_ptr_nxt;
	logic             do_write;
	logic             do_read;
	logic             has_data;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_ptr_nxt = ptr_next(wr_ptr_q);
	assign rd_ptr_nxt = ptr_next(rd_ptr_q);
	assign has_data   = full_q || (rd_ptr_q != wr_ptr_q);
	assign do_write   = push.valid && !full_q;
	assign do_read    = pop && has_data;

	assign stat.empty    = !has_data;
	assign stat.was_full = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			full_q   <= 1'b0;
		end else begin
			// push and pop come from different item kinds, never together
			if (do_write) begin
				wr_ptr_q <= wr_ptr_nxt;
				if (wr_ptr_nxt == rd_ptr_q) begin
					full_q <= 1'b1;
				end
			end
			if (do_read) begin
				rd_ptr_q <= rd_ptr_nxt;
				full_q   <= 1'b0;
			end
		end
	end

	uirx_ram #(
		.WIDTH(uirx_pkg::BYTE_W),
		.DEPTH(FIFO_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (do_write),
		.waddr(wr_ptr_q),
		.wdata(push.data),
		.re   (do_read),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

endmodule

// ===== rtl/uart_byte_receiver_fifo.sv =====
// Top level of the infrared UART byte receiver with receive FIFO.
//
// Each input beat is either a sample tick (kind = 0) carrying the receive
// line level, or a pop request (kind = 1). Ticks drive an 8N1 receiver:
// a falling edge while idle starts a frame, the first data bit is sampled
// start_delay ticks later and the rest every bit_period ticks, LSB first
// (a delay of 0 behaves as 1; the stop bit is not checked). A finished byte
// is written into a FIFO_DEPTH-entry ring buffer, or dropped when the
// buffer is full; the full condition is reported once on the next pop.
// Ticks produce no output beat; every pop produces exactly one output beat
// with data_byte, fifo_empty and was_full (an empty pop returns 0, 1, 0).
// The block takes one beat per clock while in_stall is low. A pop's flags
// and any RAM read are registered in the read stage by the accepting edge;
// the output register is loaded from the read stage when it is free or
// being taken, so an output stall holds the result in the read stage.
// in_stall rises only when the read stage and the output register both
// hold a result and the output is stalled. Configuration (index 0
// start_delay, 1 bit_period) is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle (not enforced).
module uart_byte_receiver_fifo #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [uirx_pkg::CNT_W-1:0]  cfg_data,
	// input beats
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic                        rx_level,
	// output beats
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [uirx_pkg::BYTE_W-1:0] data_byte,
	output logic                        fifo_empty,
	output logic                        was_full
);

	uirx_pkg::cfg_wr_t   cfg;
	uirx_pkg::push_t     push;
	uirx_pkg::pop_stat_t pop_stat;
	logic [uirx_pkg::BYTE_W-1:0] ram_rdata;

	logic in_acc;
	logic tick;
	logic pop;

	// read stage: flags of the pop whose RAM read is in flight
	logic                valid_s1;
	uirx_pkg::pop_stat_t stat_s1;
	logic                move_s1;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	assign in_acc = in_valid && !in_stall;
	assign tick   = in_acc && (kind == uirx_pkg::KIND_TICK);
	assign pop    = in_acc && (kind == uirx_pkg::KIND_POP);

	// read stage drains whenever the output register is free or being taken
	assign move_s1  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;

	uirx_rx u_rx (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.tick  (tick),
		.level (rx_level),
		.push  (push)
	);

	uirx_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.stat  (pop_stat),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			stat_s1 <= pop_stat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (move_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			data_byte  <= stat_s1.empty ? '0 : ram_rdata;
			fifo_empty <= stat_s1.empty;
			was_full   <= stat_s1.was_full;
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for uart_byte_receiver_fifo: line ticks and pops against a predictor.
`timescale 1ns / 100ps

module testbench;

	localparam int RX_DEPTH = 16;
	localparam int RX_PTR_W = $clog2(RX_DEPTH);

	localparam logic K_TICK = uirx_pkg::KIND_TICK;
	localparam logic K_POP  = uirx_pkg::KIND_POP;

	// One pop answer as it leaves the block
	typedef struct packed {
		logic [uirx_pkg::BYTE_W-1:0] data;
		logic                        empty;
		logic                        full;
	} rx_pop_t;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_op_t;

	// Directed row: either a beat (with an optional hand-written answer) or a register write
	typedef struct packed {
		row_op_t                    op;
		logic                       k;
		logic                       lvl;
		logic                       ix;
		logic [uirx_pkg::CNT_W-1:0] val;
		logic                       typed;
		rx_pop_t                    res;
	} stim_row_t;

	localparam rx_pop_t NO_RES    = '0;
	localparam rx_pop_t EMPTY_RES = '{8'h00, 1'b1, 1'b0};

	// Empty pop after reset; then a fast frame of 0x5A with start_delay 0
	// (acts as 1) and bit_period 1, a pop landing mid-frame.
	localparam stim_row_t DIR_TAB [17] = '{
		'{ROW_BEAT, K_POP,  1'b0, 1'b0, 16'd0, 1'b1, EMPTY_RES},
		'{ROW_CFG,  K_TICK, 1'b0, uirx_pkg::CFG_START_DELAY, 16'd0, 1'b0, NO_RES},
		'{ROW_CFG,  K_TICK, 1'b0, uirx_pkg::CFG_BIT_PERIOD,  16'd1, 1'b0, NO_RES},
		'{ROW_BEAT, K_TICK, 1'b1, 1'b0, 16'd0, 1'b0, NO_RES},
		'{ROW_BEAT, K_TICK, 1'b0, 1'b0, 16'd0, 1'b0, NO_RES},   // start edge
		'{ROW_BEAT, K_TICK, 1'b0, 1'b0, 16'd0, 1'b0, NO_RES},   // bit 0
		'{ROW_BEAT, K_TICK, 1'b1, 1'b0, 16'd0, 1'b0, NO_RES},
		'{ROW_BEAT, K_TICK, 1'b0, 1'b0, 16'd0, 1'b0, NO_RES},
		'{ROW_BEAT, K_TICK, 1'b1, 1'b0, 16'd0, 1'b0, NO_RES},
		'{ROW_BEAT, K_POP,  1'b0, 1'b0, 16'd0, 1'b1, EMPTY_RES}, // line untouched
		'{ROW_BEAT, K_TICK, 1'b1, 1'b0, 16'd0, 1'b0, NO_RES},
		'{ROW_BEAT, K_TICK, 1'b0, 1'b0, 16'd0, 1'b0, NO_RES},
		'{ROW_BEAT, K_TICK, 1'b1, 1'b0, 16'd0, 1'b0, NO_RES},
		'{ROW_BEAT, K_TICK, 1'b0, 1'b0, 16'd0, 1'b0, NO_RES},   // bit 7
		'{ROW_BEAT, K_TICK, 1'b1, 1'b0, 16'd0, 1'b0, NO_RES},   // stop, unchecked
		'{ROW_BEAT, K_POP,  1'b1, 1'b0, 16'd0, 1'b1, '{8'h5A, 1'b0, 1'b0}},
		'{ROW_BEAT, K_POP,  1'b0, 1'b0, 16'd0, 1'b1, EMPTY_RES}
	};

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        cfg_we    = 1'b0;
	logic                        cfg_index = 1'b0;
	logic [uirx_pkg::CNT_W-1:0]  cfg_data  = '0;
	logic                        in_valid  = 1'b0;
	logic                        kind      = K_TICK;
	logic                        rx_level  = 1'b1;
	logic                        in_stall;
	logic                        out_valid;
	logic                        out_stall;
	logic [uirx_pkg::BYTE_W-1:0] data_byte;
	logic                        fifo_empty;
	logic                        was_full;

	// Travels with the input beat: hand-written answer for directed pops
	logic    row_typed = 1'b0;
	rx_pop_t row_res   = '0;

	logic idle_en   = 1'b0;
	int   stall_run = 0;
	int   errors    = 0;
	int   beats_left;
	int   cur_sd    = int'(uirx_pkg::START_DELAY_RST);
	int   cur_bp    = int'(uirx_pkg::BIT_PERIOD_RST);

	always #4 clk = ~clk;

	uart_byte_receiver_fifo #(.FIFO_DEPTH(RX_DEPTH)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.rx_level   (rx_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.fifo_empty (fifo_empty),
		.was_full   (was_full)
	);

	// ---------------------------------------------------------------
	// Predictor: receiver and ring buffer at block widths
	// ---------------------------------------------------------------
	logic [uirx_pkg::CNT_W-1:0]    delay_cfg  = uirx_pkg::START_DELAY_RST;
	logic [uirx_pkg::CNT_W-1:0]    period_cfg = uirx_pkg::BIT_PERIOD_RST;
	logic                          rcv_busy   = 1'b0;
	logic                          last_level = 1'b1;
	logic [uirx_pkg::BITCNT_W-1:0] bits_got   = '0;
	logic [uirx_pkg::BYTE_W-1:0]   shift_reg  = '0;
	logic [uirx_pkg::CNT_W-1:0]    countdown  = '0;
	logic [uirx_pkg::BYTE_W-1:0]   ring [RX_DEPTH];
	logic [RX_PTR_W-1:0]           wr_ix      = '0;
	logic [RX_PTR_W-1:0]           rd_ix      = '0;
	logic                          overflow   = 1'b0;

	rx_pop_t owed_pops [$];

	function automatic logic [RX_PTR_W-1:0] ix_next(input logic [RX_PTR_W-1:0] p);
		return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + RX_PTR_W'(1);
	endfunction

	function automatic void store_byte(input logic [uirx_pkg::BYTE_W-1:0] b);
		if (overflow)
			return;   // full: byte is lost, flag stays until next pop
		ring[wr_ix] = b;
		wr_ix = ix_next(wr_ix);
		if (wr_ix == rd_ix)
			overflow = 1'b1;
	endfunction

	function automatic void line_sample(input logic lvl);
		if (!rcv_busy) begin
			// falling edge opens a frame; this tick does not count down
			if (last_level && !lvl) begin
				rcv_busy  = 1'b1;
				bits_got  = '0;
				shift_reg = '0;
				countdown = delay_cfg;
			end
		end else if (countdown <= uirx_pkg::CNT_W'(1)) begin
			// zero count behaves as one
			shift_reg[bits_got[2:0]] = shift_reg[bits_got[2:0]] | lvl;
			countdown = period_cfg;
			bits_got  = bits_got + uirx_pkg::BITCNT_W'(1);
			if (bits_got > uirx_pkg::BITCNT_W'(uirx_pkg::LAST_BIT)) begin
				rcv_busy = 1'b0;
				store_byte(shift_reg);
			end
		end else begin
			countdown = countdown - uirx_pkg::CNT_W'(1);
		end
		last_level = lvl;
	endfunction

	function automatic rx_pop_t fifo_take();
		rx_pop_t r;
		if (overflow || rd_ix != wr_ix) begin
			r = '{ring[rd_ix], 1'b0, overflow};
			rd_ix = ix_next(rd_ix);
			overflow = 1'b0;
		end else begin
			r = EMPTY_RES;
		end
		return r;
	endfunction

	task automatic report_miss(input string what, input int got, input int want);
		$display("%0t: mismatch, %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	// ---------------------------------------------------------------
	// Monitor: samples pre-edge values, so TB and DUT updates at the
	// same edge cannot race with it
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		rx_pop_t want, seen;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen = '{data_byte, fifo_empty, was_full};
				if (owed_pops.size() == 0) begin
					report_miss("result beat with no pop pending", int'(seen), 0);
				end else begin
					want = owed_pops.pop_front();
					if (seen.data != want.data)
						report_miss("data_byte", int'(seen.data), int'(want.data));
					if (seen.empty != want.empty)
						report_miss("fifo_empty", int'(seen.empty), int'(want.empty));
					if (seen.full != want.full)
						report_miss("was_full", int'(seen.full), int'(want.full));
				end
			end
			if (cfg_we) begin
				if (cfg_index == uirx_pkg::CFG_START_DELAY)
					delay_cfg = cfg_data;
				else
					period_cfg = cfg_data;
			end
			if (in_valid && !in_stall) begin
				if (kind == K_POP) begin
					want = fifo_take();
					if (row_typed)
						want = row_res;
					owed_pops.push_back(want);
				end else begin
					line_sample(rx_level);
				end
			end
		end
	end

	// Output backpressure: random bursts of stalled cycles, only while idle_en is set
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else if (idle_en && $urandom_range(0, 11) == 0) begin
			stall_run <= $urandom_range(1, 8);
		end
	end
	assign out_stall = (stall_run > 0);

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	// One input beat; returns at the edge that accepts it
	task automatic send_beat(input logic k, input logic lvl,
			input logic typed = 1'b0, input rx_pop_t res = '0);
		if (idle_en && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		rx_level  <= lvl;
		row_typed <= typed;
		row_res   <= res;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		beats_left--;
	endtask

	// Wait until every pop is answered and the pipe is quiet, then write
	task automatic write_reg(input logic ix, input logic [uirx_pkg::CNT_W-1:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_pops.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);   // trailing ticks give no result beat
		cfg_we    <= 1'b1;
		cfg_index <= ix;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (ix == uirx_pkg::CFG_START_DELAY)
			cur_sd = int'(val);
		else
			cur_bp = int'(val);
	endtask

	// 8N1 frame at the current rates; level changes halfway between samples.
	// A noisy frame flips filler ticks (edges while reading) and slips in pops.
	task automatic send_frame(input logic [uirx_pkg::BYTE_W-1:0] b, input logic noisy);
		int   span;
		logic prev, lvl;
		send_beat(K_TICK, 1'b1);
		send_beat(K_TICK, 1'b0);
		span = (cur_sd == 0) ? 1 : cur_sd;
		prev = 1'b0;
		for (int i = 0; i < 8; i++) begin
			for (int j = 1; j < span; j++) begin
				if (beats_left <= 0)
					return;
				lvl = (j < span / 2) ? prev : b[i];
				if (noisy && $urandom_range(0, 15) == 0)
					lvl = ~lvl;
				if (noisy && $urandom_range(0, 39) == 0)
					send_beat(K_POP, 1'($urandom_range(0, 1)));
				send_beat(K_TICK, lvl);
			end
			if (beats_left <= 0)
				return;
			send_beat(K_TICK, b[i]);
			prev = b[i];
			span = (cur_bp == 0) ? 1 : cur_bp;
		end
		send_beat(K_TICK, 1'b1);
	endtask

	// Mostly frames with random content; pops, line noise and cut frames between
	task automatic run_phase(input int sd, input int bp, input int budget,
			input int pop_pct, input logic gaps);
		int                          pick;
		logic [uirx_pkg::BYTE_W-1:0] b;
		write_reg(uirx_pkg::CFG_START_DELAY, sd[uirx_pkg::CNT_W-1:0]);
		write_reg(uirx_pkg::CFG_BIT_PERIOD, bp[uirx_pkg::CNT_W-1:0]);
		idle_en <= gaps;
		beats_left = budget;
		while (beats_left > 0) begin
			pick = $urandom_range(0, 99);
			if (pick < pop_pct) begin
				repeat ($urandom_range(1, 3)) send_beat(K_POP, 1'($urandom_range(0, 1)));
			end else if (pick < pop_pct + 10) begin
				repeat ($urandom_range(1, 6)) send_beat(K_TICK, 1'($urandom_range(0, 1)));
			end else begin
				case ($urandom_range(0, 9))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = uirx_pkg::BYTE_W'($urandom);
				endcase
				send_frame(b, $urandom_range(0, 2) == 0);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		beats_left = 1 << 30;
		foreach (DIR_TAB[r]) begin
			if (DIR_TAB[r].op == ROW_CFG)
				write_reg(DIR_TAB[r].ix, DIR_TAB[r].val);
			else
				send_beat(DIR_TAB[r].k, DIR_TAB[r].lvl, DIR_TAB[r].typed, DIR_TAB[r].res);
		end

		// Multi-bit counts; frames may be cut and finish under the next rates
		run_phase(40, 25, 100, 5, 1'b1);
		run_phase(9, 6, 150, 10, 1'b1);

		// Small rates, many frames: fills the ring, drops bytes, drains it
		run_phase(0, 0, 250, 3, 1'b1);
		run_phase(1, 1, 150, 30, 1'b1);
		for (int p = 0; p < 4; p++)
			run_phase($urandom_range(0, 5), $urandom_range(0, 5), 150,
				5 + $urandom_range(0, 40), (p < 3) && ($urandom_range(0, 3) != 0));

		in_valid <= 1'b0;
		@(posedge clk);
		for (int w = 0; w < 10000 && owed_pops.size() != 0; w++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (owed_pops.size() != 0)
			report_miss("pops never answered", owed_pops.size(), 0);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
